>>> rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sem_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  // Field and counter widths.
  localparam int DIM_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 11;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One gradient pair handed from the front end to the magnitude unit.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } grad_t;

endpackage

>>> rtl/sem_front.sv
// Front end: line stores, 3x3 window, position counters and gradient sums.
`timescale 1ns / 1ps

module sem_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sem_pkg::DIM_W-1:0]   width_eff,
  input  logic [sem_pkg::DIM_W-1:0]   height_eff,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sem_pkg::PIX_W-1:0]   pixel,
  input  logic                        frame_start,
  output logic                        push_valid,
  input  logic                        push_ready,
  output sem_pkg::grad_t              push_data
);

  typedef enum logic {
    F_IDLE,
    F_PROC
  } front_state_t;

  front_state_t state;

  logic [sem_pkg::COL_W-1:0] column_count;
  logic [sem_pkg::ROW_W-1:0] row_count;
  logic [sem_pkg::COL_W-1:0] col_q;
  logic [sem_pkg::ROW_W-1:0] row_q;
  logic [sem_pkg::PIX_W-1:0] pix_q;
  logic [sem_pkg::PIX_W-1:0] top_rd;
  logic [sem_pkg::PIX_W-1:0] mid_rd;
  logic [sem_pkg::PIX_W-1:0] window [6];

  logic [sem_pkg::PIX_W-1:0] line_upper  [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] line_middle [sem_pkg::MAX_WIDTH];

  logic                      accept;
  logic [sem_pkg::COL_W-1:0] col_cur;
  logic [sem_pkg::ROW_W-1:0] row_cur;
  logic                      interior;
  logic                      advance;
  logic                      col_wrap;
  logic                      row_wrap;
  logic [sem_pkg::PIX_W+1:0] right_sum;
  logic [sem_pkg::PIX_W+1:0] left_sum;
  logic [sem_pkg::PIX_W+1:0] upper_sum;
  logic [sem_pkg::PIX_W+1:0] lower_sum;

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  // A frame start beat restarts the position before it is used.
  assign col_cur = frame_start ? '0 : column_count;
  assign row_cur = frame_start ? '0 : row_count;

  // Interior test and wrap points, against the clamped geometry.
  assign interior = (row_q >= sem_pkg::ROW_W'(2)) && (col_q >= sem_pkg::COL_W'(2)) &&
                    ({1'b0, row_q} < height_eff) && ({1'b0, col_q} < width_eff);
  assign col_wrap = ({1'b0, col_q} >= width_eff - sem_pkg::DIM_W'(1));
  assign row_wrap = ({1'b0, row_q} >= height_eff - sem_pkg::DIM_W'(1));

  // The beat finishes once the result, if any, fits in the queue.
  assign advance    = (state == F_PROC) && (!interior || push_ready);
  assign push_valid = (state == F_PROC) && interior;

  // Column and row kernel sums, weights 1, 2, 1.
  assign right_sum = 10'(top_rd) + {1'b0, mid_rd, 1'b0} + 10'(pix_q);
  assign left_sum  = 10'(window[0]) + {1'b0, window[1], 1'b0} + 10'(window[2]);
  assign upper_sum = 10'(window[0]) + {1'b0, window[3], 1'b0} + 10'(top_rd);
  assign lower_sum = 10'(window[2]) + {1'b0, window[5], 1'b0} + 10'(pix_q);

  assign push_data.gx   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
  assign push_data.gy   = $signed({1'b0, upper_sum}) - $signed({1'b0, lower_sum});
  assign push_data.last = ({1'b0, row_q} == height_eff - sem_pkg::DIM_W'(1)) &&
                          ({1'b0, col_q} == width_eff - sem_pkg::DIM_W'(1));

  // Line stores: read on the accepting edge, written back when the beat finishes.
  always_ff @(posedge clk) begin
    if (accept) begin
      top_rd <= line_upper[col_cur];
      mid_rd <= line_middle[col_cur];
    end
    if (advance) begin
      line_upper[col_q]  <= mid_rd;
      line_middle[col_q] <= pix_q;
    end
  end

  // Sequencer, counters and window.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            col_q <= col_cur;
            row_q <= row_cur;
            pix_q <= pixel;
            state <= F_PROC;
          end
        end
        F_PROC: begin
          if (advance) begin
            window[0] <= window[3];
            window[1] <= window[4];
            window[2] <= window[5];
            window[3] <= top_rd;
            window[4] <= mid_rd;
            window[5] <= pix_q;
            if (col_wrap) begin
              column_count <= '0;
              row_count    <= row_wrap ? '0 : row_q + sem_pkg::ROW_W'(1);
            end else begin
              column_count <= col_q + sem_pkg::COL_W'(1);
              row_count    <= row_q;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sem_queue.sv
// Four-entry queue of gradient pairs between the front end and the magnitude unit.
`timescale 1ns / 1ps

module sem_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sem_pkg::grad_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sem_pkg::grad_t pop_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  sem_pkg::grad_t      entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W:0]      count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sem_back.sv
// Magnitude unit: squares, sum, bit-serial square root and output register.
`timescale 1ns / 1ps

module sem_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  sem_pkg::grad_t             pop_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sem_pkg::PIX_W-1:0]  magnitude,
  output logic                       last_of_frame
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_SUM,
    B_ROOT,
    B_OUT
  } back_state_t;

  back_state_t state;

  logic [19:0] sq_x;
  logic [19:0] sq_y;
  logic        last_q;
  logic [15:0] rem;
  logic [15:0] root;
  logic [2:0]  step;

  logic signed [sem_pkg::GRAD_W-1:0] neg_x;
  logic signed [sem_pkg::GRAD_W-1:0] neg_y;
  logic [9:0]  abs_x;
  logic [9:0]  abs_y;
  logic [20:0] sum;
  logic [15:0] bit_val;
  logic [16:0] trial;
  logic        take;
  logic        out_free;

  assign pop_ready = (state == B_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Absolute gradients; their magnitudes stay below 1024.
  assign neg_x = -pop_data.gx;
  assign neg_y = -pop_data.gy;
  assign abs_x = pop_data.gx[sem_pkg::GRAD_W-1] ? neg_x[9:0] : pop_data.gx[9:0];
  assign abs_y = pop_data.gy[sem_pkg::GRAD_W-1] ? neg_y[9:0] : pop_data.gy[9:0];

  assign sum = {1'b0, sq_x} + {1'b0, sq_y};

  // One digit of the square root per cycle.
  assign bit_val = 16'(1) << {step, 1'b0};
  assign trial   = {1'b0, root} + {1'b0, bit_val};
  assign take    = ({1'b0, rem} >= trial);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register fills from B_OUT and empties on a handshake.
      if (state == B_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            sq_x   <= {10'd0, abs_x} * {10'd0, abs_x};
            sq_y   <= {10'd0, abs_y} * {10'd0, abs_y};
            last_q <= pop_data.last;
            state  <= B_SUM;
          end
        end
        B_SUM: begin
          // Sums of 65536 and above saturate the result.
          if (sum[20:16] != '0) begin
            root  <= 16'd255;
            state <= B_OUT;
          end else begin
            rem   <= sum[15:0];
            root  <= '0;
            step  <= 3'd7;
            state <= B_ROOT;
          end
        end
        B_ROOT: begin
          if (take) begin
            rem  <= rem - trial[15:0];
            root <= (root >> 1) + bit_val;
          end else begin
            root <= root >> 1;
          end
          step <= step - 3'd1;
          if (step == 3'd0) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            magnitude     <= root[7:0];
            last_of_frame <= last_q;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // The root iteration always ends after its last digit.
  a_root_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROOT && step == 3'd0) |=> (state == B_OUT))
    else $error("square root did not finish after the last digit");

  // A finished magnitude always fits in eight bits.
  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT) |-> (root[15:8] == '0))
    else $error("square root result exceeds eight bits");

  // A result leaves the output register only through a handshake.
  a_out_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output beat dropped without being taken");

  // A new result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_valid && !out_ready) |=> (state == B_OUT))
    else $error("output register overwritten while stalled");

endmodule

>>> rtl/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Pixels enter in raster order on the in channel (in_valid, in_ready, pixel,
// frame_start); a beat with frame_start high is row 0, column 0 of a frame.
// One magnitude beat leaves on the out channel (out_valid, out_ready, magnitude,
// last_of_frame) for each interior pixel, once the pixel below and to the right
// of it has been taken; last_of_frame marks the last interior pixel of a frame.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// frame_width (index 0) and frame_height (index 1); it is always ready. The
// user must see that it is written only while the block is idle; the block
// does not enforce this. Both are clamped to 3..1024 in use. The front end
// reads the two line stores when it accepts a pixel, then writes them back
// and forms the gradients, and takes no new pixel until it finishes. The
// magnitude unit forms squares, sum, eight square-root digits (skipped when
// the sum saturates) and output, and takes no new pair until it is done; a
// four-beat queue lets border pixels flow while it works.
// Reset returns the geometry to 320 by 240, clears the counters and window and
// empties the queue; line store contents are not cleared. When out_ready is
// low the result holds in the output register, then the queue fills and
// in_ready drops.
`timescale 1ns / 1ps

module sobel_edge_magnitude (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sem_pkg::PIX_W-1:0]      pixel,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sem_pkg::PIX_W-1:0]      magnitude,
  output logic                           last_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::DIM_W-1:0]      cfg_data
);

  logic [sem_pkg::DIM_W-1:0] frame_width;
  logic [sem_pkg::DIM_W-1:0] frame_height;
  logic [sem_pkg::DIM_W-1:0] width_eff;
  logic [sem_pkg::DIM_W-1:0] height_eff;

  logic           push_valid;
  logic           push_ready;
  sem_pkg::grad_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  sem_pkg::grad_t pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::DIM_W'(320);
      frame_height <= sem_pkg::DIM_W'(240);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sem_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  // Geometry in use, clamped to the supported range.
  always_comb begin
    if (frame_width < sem_pkg::DIM_W'(sem_pkg::MIN_DIM)) begin
      width_eff = sem_pkg::DIM_W'(sem_pkg::MIN_DIM);
    end else if (frame_width > sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH)) begin
      width_eff = sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    if (frame_height < sem_pkg::DIM_W'(sem_pkg::MIN_DIM)) begin
      height_eff = sem_pkg::DIM_W'(sem_pkg::MIN_DIM);
    end else if (frame_height > sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT)) begin
      height_eff = sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  sem_front u_front (
    .clk         (clk),
    .rst         (rst),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  sem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sem_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .magnitude     (magnitude),
    .last_of_frame (last_of_frame)
  );

endmodule
